/* src/ipf_pkg.sv */
// ipf_pkg: shared types, codes and constants of the ipv4 source address filter
// used by every module under src; depends on nothing
package ipf_pkg;

	// field widths of the word fixed by the frame format
	localparam int BYTE_W      = 8;
	localparam int ADDR_W      = 32;
	localparam int COUNT_W     = 32;
	localparam int REASON_W    = 3;
	localparam int POS_W       = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int ENTRIES_W   = 3;

	// frame layout, byte offsets from the destination mac
	localparam logic [POS_W-1:0] POS_ETHER_HI = 6'd12;
	localparam logic [POS_W-1:0] POS_ETHER_LO = 6'd13;
	localparam logic [POS_W-1:0] POS_PROTO    = 6'd23;
	localparam logic [POS_W-1:0] POS_SRC_FIRST = 6'd26;
	localparam logic [POS_W-1:0] POS_SRC_LAST = 6'd29;
	localparam logic [POS_W-1:0] ETH_HDR_LEN  = 6'd14;
	localparam logic [POS_W-1:0] IP_END_LEN   = 6'd34;

	localparam logic [15:0]        ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [BYTE_W-1:0]  PROTOCOL_UDP   = 8'd17;

	// configuration defaults
	localparam int                   ADDRESS_SLOTS_DEF = 4;
	localparam int                   QUEUE_DEPTH_DEF   = 4;
	localparam logic [ADDR_W-1:0]    DEFAULT_BLOCKED   = 32'hC0A80065;
	localparam logic [ENTRIES_W-1:0] DEFAULT_ENTRIES   = 3'd1;
	localparam logic [COUNT_W-1:0]   DEFAULT_THRESHOLD = 32'd8;
	localparam logic [COUNT_W-1:0]   COUNT_MAX         = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;

	// reason codes
	localparam logic [REASON_W-1:0] REASON_SHORT    = 3'd0;
	localparam logic [REASON_W-1:0] REASON_NOT_IPV4 = 3'd1;
	localparam logic [REASON_W-1:0] REASON_NOT_UDP  = 3'd2;
	localparam logic [REASON_W-1:0] REASON_NO_MATCH = 3'd3;
	localparam logic [REASON_W-1:0] REASON_PASSED   = 3'd4;
	localparam logic [REASON_W-1:0] REASON_DROPPED  = 3'd5;

	// frame class decided by the parser
	typedef enum logic [1:0] {
		KIND_SHORT,
		KIND_NOT_IPV4,
		KIND_NOT_UDP,
		KIND_CHECK
	} frame_kind_t;

	typedef struct packed {
		frame_kind_t       kind;
		logic [ADDR_W-1:0] src_addr;
	} frame_rec_t;

	typedef struct packed {
		logic [BYTE_W-1:0] packet_byte;
		logic              last_byte;
	} in_word_t;

	typedef struct packed {
		logic                verdict;
		logic [REASON_W-1:0] reason;
		logic [COUNT_W-1:0]  match_total;
	} out_word_t;

endpackage

/* src/ipf_front.sv */
// ipf_front: byte parser; captures header fields and classifies each frame
// depends on ipf_pkg
module ipf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  ipf_pkg::in_word_t word,
	output logic              rec_push,
	output ipf_pkg::frame_rec_t rec
);
	import ipf_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [15:0]       ether_q;
	logic [BYTE_W-1:0] proto_q;
	logic [ADDR_W-1:0] src_q;
	logic [POS_W-1:0]  pos_next;
	logic [15:0]       ether_now;

	// byte position, saturating at the end of the ip header
	always_comb begin
		pos_next = (pos_q < IP_END_LEN) ? pos_q + 1'b1 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= word.last_byte ? '0 : pos_next;
		end
	end

	// header field capture
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == POS_ETHER_HI || pos_q == POS_ETHER_LO) begin
				ether_q <= {ether_q[7:0], word.packet_byte};
			end else if (pos_q == POS_PROTO) begin
				proto_q <= word.packet_byte;
			end else if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) begin
				src_q <= {src_q[ADDR_W-BYTE_W-1:0], word.packet_byte};
			end
		end
	end

	// classification on the final byte, ethertype may finish on this byte
	always_comb begin
		ether_now = (pos_q == POS_ETHER_LO) ? {ether_q[7:0], word.packet_byte} : ether_q;
		rec_push = accept && word.last_byte;
		rec.src_addr = src_q;
		if (pos_next < ETH_HDR_LEN) begin
			rec.kind = KIND_SHORT;
		end else if (ether_now != ETHERTYPE_IPV4) begin
			rec.kind = KIND_NOT_IPV4;
		end else if (pos_next < IP_END_LEN) begin
			rec.kind = KIND_SHORT;
		end else if (proto_q != PROTOCOL_UDP) begin
			rec.kind = KIND_NOT_UDP;
		end else begin
			rec.kind = KIND_CHECK;
		end
	end

endmodule

/* src/ipf_queue.sv */
// ipf_queue: short first-in first-out queue of frame records
// depends on ipf_pkg
module ipf_queue #(
	parameter int DEPTH = ipf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  ipf_pkg::frame_rec_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output ipf_pkg::frame_rec_t rd_data,
	output logic                empty
);
	import ipf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_rec_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue fill count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not rise on write");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not fall on read");

endmodule

/* src/ipf_back.sv */
// ipf_back: address compare, match counter and result register
// depends on ipf_pkg; holds the configuration registers
module ipf_back #(
	parameter int ADDRESS_SLOTS = ipf_pkg::ADDRESS_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ipf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ipf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                rec_avail,
	input  ipf_pkg::frame_rec_t                 rec,
	output logic                                rec_pop,
	output logic                                empty,
	input  logic                                pop,
	output ipf_pkg::out_word_t                  result
);
	import ipf_pkg::*;

	logic [ADDR_W-1:0]    blocked_q [ADDRESS_SLOTS];
	logic [ENTRIES_W-1:0] entries_q;
	logic [COUNT_W-1:0]   threshold_q;

	logic                 valid_s1;
	frame_kind_t          kind_s1;
	logic                 hit_s1;
	logic                 valid_s2;
	out_word_t            res_s2;
	logic [COUNT_W-1:0]   counter_q;

	logic [ADDRESS_SLOTS-1:0] slot_hit;
	logic                 load_s1;
	logic                 load_s2;
	logic [COUNT_W-1:0]   count_inc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ADDRESS_SLOTS; i++) begin
				blocked_q[i] <= (i == 0) ? DEFAULT_BLOCKED : '0;
			end
			entries_q   <= DEFAULT_ENTRIES;
			threshold_q <= DEFAULT_THRESHOLD;
		end else if (cfg_write) begin
			for (int i = 0; i < ADDRESS_SLOTS; i++) begin
				if (cfg_index == CFG_BLOCKED_0 + CFG_IDX_W'(i)) begin
					blocked_q[i] <= cfg_data[ADDR_W-1:0];
				end
			end
			if (cfg_index == CFG_ENTRIES) begin
				entries_q <= cfg_data[ENTRIES_W-1:0];
			end
			if (cfg_index == CFG_THRESHOLD) begin
				threshold_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	// handshake between stages
	assign load_s2 = valid_s1 && (!valid_s2 || pop);
	assign load_s1 = !valid_s1 || load_s2;
	assign rec_pop = rec_avail && load_s1;
	assign empty   = !valid_s2;
	assign result  = res_s2;

	// compare against the blocked addresses in use
	always_comb begin
		for (int i = 0; i < ADDRESS_SLOTS; i++) begin
			slot_hit[i] = (blocked_q[i] == rec.src_addr) && (ENTRIES_W'(i) < entries_q);
		end
	end

	// stage 1: class and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= rec_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			kind_s1 <= rec.kind;
			hit_s1  <= |slot_hit;
		end
	end

	// saturating increment of the match counter
	assign count_inc = (counter_q == COUNT_MAX) ? counter_q : counter_q + 1'b1;

	// stage 2: counter update and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			counter_q <= '0;
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
				if (kind_s1 == KIND_CHECK && hit_s1) begin
					counter_q <= count_inc;
				end
			end else if (pop) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2.verdict     <= 1'b0;
			res_s2.match_total <= counter_q;
			case (kind_s1)
				KIND_SHORT:    res_s2.reason <= REASON_SHORT;
				KIND_NOT_IPV4: res_s2.reason <= REASON_NOT_IPV4;
				KIND_NOT_UDP:  res_s2.reason <= REASON_NOT_UDP;
				KIND_CHECK: begin
					if (!hit_s1) begin
						res_s2.reason <= REASON_NO_MATCH;
					end else begin
						res_s2.match_total <= count_inc;
						if (count_inc < threshold_q) begin
							res_s2.reason <= REASON_PASSED;
						end else begin
							res_s2.reason  <= REASON_DROPPED;
							res_s2.verdict <= 1'b1;
						end
					end
				end
				default:       res_s2.reason <= REASON_SHORT;
			endcase
		end
	end

	a_count_moves_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		(counter_q != $past(counter_q)) |-> $past(load_s2 && hit_s1 && kind_s1 == KIND_CHECK))
		else $error("match counter moved without a matched word");

	a_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.verdict) |-> (res_s2.reason == REASON_DROPPED))
		else $error("drop verdict without dropped reason");

	a_total_tracks_counter: assert property (@(posedge clk) disable iff (!arst_n)
		$past(load_s2) |-> (res_s2.match_total == counter_q))
		else $error("result total differs from match counter");

endmodule

/* src/udp_source_address_blocker_top.sv */
// udp_source_address_blocker_top: one byte per cycle in, one verdict word per frame out.
// A frame's record goes via the queue and back end registers; a held result stalls it.
// Throughput: one byte per cycle unless full, one frame record per cycle unless stalled.
// Reset: arst_n clears positions, queue, counter and restores register defaults.
// depends on ipf_pkg, ipf_front, ipf_queue, ipf_back
module udp_source_address_blocker_top #(
	parameter int ADDRESS_SLOTS = ipf_pkg::ADDRESS_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  ipf_pkg::in_word_t              item,
	output logic                           empty,
	input  logic                           pop,
	output ipf_pkg::out_word_t             result,
	input  logic                           cfg_write,
	input  logic [ipf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ipf_pkg::*;

	logic       accept;
	logic       rec_push;
	frame_rec_t rec_in;
	frame_rec_t rec_out;
	logic       q_empty;
	logic       rec_pop;

	assign accept = push && !full;

	// parser
	ipf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.word     (item),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	// record queue between parser and decision logic
	ipf_queue #(
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_in),
		.full    (full),
		.rd_en   (rec_pop),
		.rd_data (rec_out),
		.empty   (q_empty)
	);

	// decision logic and result register
	ipf_back #(
		.ADDRESS_SLOTS (ADDRESS_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec_avail (!q_empty),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

/* sim/udp_source_address_blocker_top_test.sv */
// udp_source_address_blocker_top_test: self-checking bench for the ipv4 source address filter
// drives frames byte by byte, predicts every verdict word and checks it field by field
// depends on ipf_pkg and udp_source_address_blocker_top
`timescale 1ns / 1ps

module udp_source_address_blocker_top_test;
	import ipf_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int SETTLE_CYCLES    = 6;
	localparam int HOLD_CYCLES      = 300;
	localparam int PHASE_BYTES      = 30;
	localparam int HOLD_PHASE_BYTES = 280;
	localparam int ROWS             = 21;

	// one directed frame, optionally preceded by one register write; len 0 means write only
	typedef struct packed {
		logic                  cfg_en;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_val;
		logic [6:0]            len;
		logic [15:0]           etype;
		logic [BYTE_W-1:0]     proto;
		logic [ADDR_W-1:0]     src;
		logic [BYTE_W-1:0]     fill;
		logic                  typed;
		logic                  exp_verdict;
		logic [REASON_W-1:0]   exp_reason;
		logic [COUNT_W-1:0]    exp_total;
	} frame_row_t;

	typedef struct {
		bit        typed;
		out_word_t word;
	} frame_note_t;

	// directed frames: header boundaries, every reason, entry count and threshold extremes
	localparam frame_row_t DIRECTED_ROWS [ROWS] = '{
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd1, 16'h0000, 8'h00, 32'h0, 8'hFF,
			1'b1, 1'b0, REASON_SHORT, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd13, 16'h0000, 8'h00, 32'h0, 8'h00,
			1'b1, 1'b0, REASON_SHORT, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd14, 16'h0800, 8'h00, 32'h0, 8'h00,
			1'b1, 1'b0, REASON_SHORT, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd14, 16'h86DD, 8'h00, 32'h0, 8'hFF,
			1'b1, 1'b0, REASON_NOT_IPV4, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd33, 16'h0800, 8'h11, 32'hC0A80065, 8'hFF,
			1'b1, 1'b0, REASON_SHORT, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd34, 16'h0800, 8'h06, 32'hC0A80065, 8'h00,
			1'b1, 1'b0, REASON_NOT_UDP, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd34, 16'h0800, 8'h11, 32'h0A000001, 8'h00,
			1'b1, 1'b0, REASON_NO_MATCH, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd34, 16'h0800, 8'h11, 32'hC0A80065, 8'h00,
			1'b1, 1'b0, REASON_PASSED, 32'd1},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd60, 16'h0800, 8'h11, 32'hC0A80065, 8'hFF,
			1'b0, 1'b0, REASON_SHORT, 32'd0},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd40, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 8'hFF,
			1'b1, 1'b0, REASON_NOT_IPV4, 32'd2},
		'{1'b1, CFG_ENTRIES, 32'h0, 7'd34, 16'h0800, 8'h11, 32'hC0A80065, 8'h00,
			1'b1, 1'b0, REASON_NO_MATCH, 32'd2},
		'{1'b1, CFG_BLOCKED_0 + 3'd3, 32'hFFFFFFFF, 7'd0, 16'h0, 8'h00, 32'h0, 8'h00,
			1'b0, 1'b0, REASON_SHORT, 32'd0},
		'{1'b1, CFG_ENTRIES, 32'h4, 7'd0, 16'h0, 8'h00, 32'h0, 8'h00,
			1'b0, 1'b0, REASON_SHORT, 32'd0},
		'{1'b1, CFG_THRESHOLD, 32'h0, 7'd34, 16'h0800, 8'h11, 32'hFFFFFFFF, 8'hFF,
			1'b1, 1'b1, REASON_DROPPED, 32'd3},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd34, 16'h0800, 8'h11, 32'h00000000, 8'h00,
			1'b1, 1'b1, REASON_DROPPED, 32'd4},
		'{1'b1, CFG_ENTRIES, 32'h7, 7'd0, 16'h0, 8'h00, 32'h0, 8'h00,
			1'b0, 1'b0, REASON_SHORT, 32'd0},
		'{1'b1, CFG_THRESHOLD, 32'hFFFFFFFF, 7'd34, 16'h0800, 8'h11, 32'h0, 8'h00,
			1'b1, 1'b0, REASON_PASSED, 32'd5},
		'{1'b1, CFG_BLOCKED_0 + 3'd2, 32'h7F000001, 7'd0, 16'h0, 8'h00, 32'h0, 8'h00,
			1'b0, 1'b0, REASON_SHORT, 32'd0},
		'{1'b1, CFG_THRESHOLD, 32'h6, 7'd35, 16'h0800, 8'h11, 32'h7F000001, 8'h5A,
			1'b1, 1'b1, REASON_DROPPED, 32'd6},
		'{1'b1, CFG_BLOCKED_0 + 3'd1, 32'h0A0B0C0D, 7'd34, 16'h0800, 8'h11, 32'h0A0B0C0D,
			8'hA5, 1'b1, 1'b1, REASON_DROPPED, 32'd7},
		'{1'b0, CFG_ENTRIES, 32'h0, 7'd34, 16'h0801, 8'h11, 32'h0A0B0C0D, 8'h00,
			1'b0, 1'b0, REASON_SHORT, 32'd0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	in_word_t              item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	out_word_t             result;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// register copies kept by the bench
	logic [ADDR_W-1:0]    cfg_blocked [4] = '{DEFAULT_BLOCKED, 32'h0, 32'h0, 32'h0};
	logic [ENTRIES_W-1:0] cfg_entries     = DEFAULT_ENTRIES;
	logic [COUNT_W-1:0]   cfg_threshold   = DEFAULT_THRESHOLD;

	// filter state kept by the bench
	logic [POS_W-1:0]   m_pos     = '0;
	logic [15:0]        m_etype   = '0;
	logic [BYTE_W-1:0]  m_proto   = '0;
	logic [ADDR_W-1:0]  m_src     = '0;
	logic [COUNT_W-1:0] m_matches = '0;

	out_word_t   pending_verdicts [$];
	frame_note_t frame_notes [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_asked    = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int cycle_count   = 0;
	int errors        = 0;
	int frames_sent   = 0;
	int verdicts_in   = 0;
	int bytes_in      = 0;
	int drops_seen    = 0;
	int full_stalls   = 0;

	bit          byte_made;
	out_word_t   byte_guess;
	frame_note_t byte_note;
	out_word_t   got_word;

	udp_source_address_blocker_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= 40) begin
			$display("mismatch %0d: %s got %0h want %0h (verdict %0d, cycle %0d)",
				errors, what, got, want, verdicts_in, cycle_count);
		end
	endtask

	// advance the filter copy by one byte; gives a verdict word on the final byte
	function automatic void classify_byte(input in_word_t w, output bit made,
			output out_word_t v);
		logic [POS_W-1:0] len;
		bit               hit;
		int               n;
		made = 1'b0;
		v = '0;
		if (m_pos == POS_ETHER_HI || m_pos == POS_ETHER_LO) begin
			m_etype = {m_etype[7:0], w.packet_byte};
		end else if (m_pos == POS_PROTO) begin
			m_proto = w.packet_byte;
		end else if (m_pos >= POS_SRC_FIRST && m_pos <= POS_SRC_LAST) begin
			m_src = {m_src[23:0], w.packet_byte};
		end
		if (m_pos < IP_END_LEN) begin
			m_pos = m_pos + 1'b1;
		end
		if (!w.last_byte) begin
			return;
		end
		len = m_pos;
		m_pos = '0;
		made = 1'b1;
		// entry counts above the slot count compare every slot
		n = (cfg_entries > ADDRESS_SLOTS_DEF) ? ADDRESS_SLOTS_DEF : int'(cfg_entries);
		hit = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (cfg_blocked[i] == m_src) begin
				hit = 1'b1;
			end
		end
		if (len < ETH_HDR_LEN) begin
			v.reason = REASON_SHORT;
		end else if (m_etype != ETHERTYPE_IPV4) begin
			v.reason = REASON_NOT_IPV4;
		end else if (len < IP_END_LEN) begin
			v.reason = REASON_SHORT;
		end else if (m_proto != PROTOCOL_UDP) begin
			v.reason = REASON_NOT_UDP;
		end else if (!hit) begin
			v.reason = REASON_NO_MATCH;
		end else begin
			if (m_matches != COUNT_MAX) begin
				m_matches = m_matches + 1'b1;
			end
			if (m_matches < cfg_threshold) begin
				v.reason = REASON_PASSED;
			end else begin
				v.reason = REASON_DROPPED;
				v.verdict = 1'b1;
			end
		end
		v.match_total = m_matches;
	endfunction

	// check the delivered word, then predict from the accepted byte
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (pop && !empty) begin
				verdicts_in++;
				if (pending_verdicts.size() == 0) begin
					report_mismatch("verdict word with none expected", result.match_total,
						32'h0);
				end else begin
					got_word = pending_verdicts.pop_front();
					if (result.verdict !== got_word.verdict) begin
						report_mismatch("verdict", 32'(result.verdict),
							32'(got_word.verdict));
					end
					if (result.reason !== got_word.reason) begin
						report_mismatch("reason", 32'(result.reason),
							32'(got_word.reason));
					end
					if (result.match_total !== got_word.match_total) begin
						report_mismatch("match_total", result.match_total,
							got_word.match_total);
					end
				end
			end
			if (push && full) begin
				full_stalls++;
			end
			if (push && !full) begin
				bytes_in++;
				classify_byte(item, byte_made, byte_guess);
				if (byte_made) begin
					byte_note.typed = 1'b0;
					byte_note.word = byte_guess;
					if (frame_notes.size() > 0) begin
						byte_note = frame_notes.pop_front();
					end
					if (byte_note.typed) begin
						pending_verdicts.push_back(byte_note.word);
					end else begin
						pending_verdicts.push_back(byte_guess);
					end
					if (byte_guess.verdict) begin
						drops_seen++;
					end
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
		end
		$display("FAIL");
		$finish;
	end

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
	endtask

	task automatic send_frame(input int unsigned len, input logic [15:0] etype,
			input logic [BYTE_W-1:0] proto, input logic [ADDR_W-1:0] src,
			input logic [BYTE_W-1:0] fill, input bit rand_fill, input frame_note_t note);
		in_word_t w;
		for (int i = 0; i < len; i++) begin
			w.packet_byte = rand_fill ? BYTE_W'($urandom()) : fill;
			case (i)
				POS_ETHER_HI:  w.packet_byte = etype[15:8];
				POS_ETHER_LO:  w.packet_byte = etype[7:0];
				POS_PROTO:     w.packet_byte = proto;
				POS_SRC_FIRST: w.packet_byte = src[31:24];
				POS_SRC_FIRST + 1: w.packet_byte = src[23:16];
				POS_SRC_FIRST + 2: w.packet_byte = src[15:8];
				POS_SRC_LAST:  w.packet_byte = src[7:0];
				default: ;
			endcase
			w.last_byte = (i == len - 1);
			if (i == 0) begin
				frame_notes.push_back(note);
			end
			send_word(w);
		end
		frames_sent++;
	endtask

	// lower push, then wait until every verdict is back and the back end has settled
	task automatic wait_idle();
		push <= 1'b0;
		while (verdicts_in < frames_sent) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < CFG_ENTRIES) begin
			cfg_blocked[idx[1:0]] = val;
		end else if (idx == CFG_ENTRIES) begin
			cfg_entries = val[ENTRIES_W-1:0];
		end else if (idx == CFG_THRESHOLD) begin
			cfg_threshold = val;
		end
		@(posedge clk);
	endtask

	task automatic close_writes();
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// fresh register set for a traffic phase
	task automatic random_setup(input logic [COUNT_W-1:0] threshold);
		logic [ADDR_W-1:0]    a;
		logic [ENTRIES_W-1:0] e;
		wait_idle();
		for (int k = 0; k < 4; k++) begin
			a = $urandom();
			if ($urandom_range(9) == 0) begin
				a = ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFFFFFF;
			end
			set_reg(CFG_BLOCKED_0 + CFG_IDX_W'(k), a);
		end
		e = ($urandom_range(3) == 0) ? ENTRIES_W'($urandom_range(7)) :
			ENTRIES_W'($urandom_range(1, 4));
		set_reg(CFG_ENTRIES, CFG_DATA_W'(e));
		set_reg(CFG_THRESHOLD, threshold);
		close_writes();
	endtask

	// half of them well-formed udp frames, the rest short, foreign or non-udp
	task automatic random_frame();
		int unsigned       len;
		int unsigned       roll;
		logic [15:0]       etype;
		logic [BYTE_W-1:0] proto;
		logic [ADDR_W-1:0] src;
		frame_note_t       note;
		note.typed = 1'b0;
		note.word = '0;
		roll = $urandom_range(99);
		etype = ETHERTYPE_IPV4;
		proto = PROTOCOL_UDP;
		src = $urandom();
		if (roll < 15) begin
			len = $urandom_range(1, 13);
		end else if (roll < 25) begin
			len = $urandom_range(14, 40);
			etype = ($urandom_range(1) == 0) ? 16'($urandom()) :
				16'h0800 ^ (16'h1 << $urandom_range(15));
		end else if (roll < 35) begin
			len = $urandom_range(14, 33);
		end else if (roll < 50) begin
			len = $urandom_range(34, 40);
			proto = BYTE_W'($urandom());
		end else begin
			len = ($urandom_range(19) == 0) ? $urandom_range(64, 80) : $urandom_range(34, 44);
			if ($urandom_range(99) < 65) begin
				src = cfg_blocked[$urandom_range(3)];
			end
		end
		send_frame(len, etype, proto, src, 8'h00, 1'b1, note);
	endtask

	task automatic run_traffic(input int idle_v, input int stall_v, input bit hold,
			input int n_bytes);
		int start;
		send_idle_pct = idle_v;
		stall_pct = stall_v;
		if (hold) begin
			hold_asked++;
		end
		start = bytes_in;
		while (bytes_in < start + n_bytes) begin
			random_frame();
		end
	endtask

	// main sequence
	initial begin
		frame_note_t note;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames
		for (int r = 0; r < ROWS; r++) begin
			if (DIRECTED_ROWS[r].cfg_en) begin
				wait_idle();
				set_reg(DIRECTED_ROWS[r].cfg_idx, DIRECTED_ROWS[r].cfg_val);
				close_writes();
			end
			if (DIRECTED_ROWS[r].len != 0) begin
				note.typed = DIRECTED_ROWS[r].typed;
				note.word.verdict = DIRECTED_ROWS[r].exp_verdict;
				note.word.reason = DIRECTED_ROWS[r].exp_reason;
				note.word.match_total = DIRECTED_ROWS[r].exp_total;
				send_frame(DIRECTED_ROWS[r].len, DIRECTED_ROWS[r].etype,
					DIRECTED_ROWS[r].proto, DIRECTED_ROWS[r].src,
					DIRECTED_ROWS[r].fill, 1'b0, note);
			end
		end

		// random traffic phases, each under its own register set
		random_setup(32'h0);
		run_traffic(0, 0, 1'b0, PHASE_BYTES);
		random_setup(COUNT_W'($urandom_range(1, 10)));
		run_traffic(58, 0, 1'b0, PHASE_BYTES);
		random_setup(COUNT_MAX);
		run_traffic(0, 58, 1'b0, PHASE_BYTES);
		random_setup(COUNT_W'($urandom_range(2, 30)));
		run_traffic(20, 20, 1'b0, PHASE_BYTES);
		random_setup(32'd3);
		run_traffic(0, 0, 1'b1, HOLD_PHASE_BYTES);
		wait_idle();

		if (pending_verdicts.size() > 0) begin
			report_mismatch("verdict words never delivered", pending_verdicts.size(), 32'h0);
		end
		$display("covered %0d frames (%0d bytes) in directed rows and five traffic phases",
			frames_sent, bytes_in);
		$display("%0d verdict words checked, %0d drops, %0d stalled pushes, final count %0d",
			verdicts_in, drops_seen, full_stalls, m_matches);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
